// ===== design/kl_pkg.sv =====
// Package for the keyed lock table: sizes, codes, state and handshake types.
// Used by kl_match, kl_notes and keyed_lock_table; it depends on nothing else.

package kl_pkg;

    // Table geometry.
    localparam int SLOTS     = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SLOT_FW   = 5;            // width of the slot field on the bus
    localparam int KEY_W     = 128;
    localparam int TIME_W    = 32;
    localparam int HOLD_W    = 16;
    localparam int MAX_NOTES = 32;
    localparam int CNT_W     = $clog2(MAX_NOTES + 1);

    // Bus layout.
    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 8;
    localparam int NOTICE_W    = 3;

    localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd30;
    localparam logic [BYTE_W-1:0] RELEASE_BYTE = 8'h52;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CONNECT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KEY     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HANGUP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OWNER   = 2'd1,
        MODE_KEYWAIT = 2'd2,
        MODE_WAITER  = 2'd3
    } t_mode;

    typedef enum logic [NOTICE_W-1:0] {
        N_GRANTED = 3'd0,
        N_WAITING = 3'd1,
        N_WOKEN   = 3'd2,
        N_CLOSED  = 3'd3,
        N_REOPEN  = 3'd4,
        N_IGNORED = 3'd5
    } t_notice;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAB,
        S_WAKE,
        S_TICK,
        S_REQ,
        S_LAST,
        S_FLUSH
    } t_state;

    // Request from the sequencer to the notice stage.
    typedef struct packed {
        logic               emit;
        logic               flush;
        logic [SLOT_FW-1:0] slot;
        t_notice            code;
    } t_note_req;

    // Status from the notice stage back to the sequencer.
    typedef struct packed {
        logic emit_ok;
        logic flush_ok;
    } t_note_st;

endpackage

// ===== design/kl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth come in as parameters.

module kl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/kl_match.sv =====
// Shared compare unit: key equality and wrap-safe deadline expiry.
// Depends on kl_pkg for the key and time widths.

module kl_match (
    input  logic [kl_pkg::KEY_W-1:0]  i_key_a,
    input  logic [kl_pkg::KEY_W-1:0]  i_key_b,
    input  logic [kl_pkg::TIME_W-1:0] i_now,
    input  logic [kl_pkg::TIME_W-1:0] i_deadline,
    output logic                      o_eq,
    output logic                      o_expired
);
    import kl_pkg::*;

    logic [TIME_W-1:0] diff;

    assign diff      = i_now - i_deadline;
    assign o_eq      = (i_key_a == i_key_b);
    // The deadline has passed when now minus deadline is not negative.
    assign o_expired = ~diff[TIME_W-1];

endmodule

// ===== design/kl_notes.sv =====
// Notice stage: holds one notice back so the final one of an item can carry
// tlast, then drives the master side through an output register. Uses kl_pkg.

module kl_notes (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kl_pkg::t_note_req              i_req,
    output kl_pkg::t_note_st               o_st,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [kl_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // [4:0] target_slot, rest zero
    output logic [kl_pkg::NOTICE_W-1:0]    o_m_tuser,   // [2:0] notice
    output logic                           o_m_tlast
);
    import kl_pkg::*;

    logic               r_pv;
    logic [SLOT_FW-1:0] r_pslot;
    t_notice            r_pcode;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ov;
    logic [SLOT_FW-1:0] r_oslot;
    t_notice            r_ocode;
    logic               r_olast;

    logic out_free;
    logic capped;
    logic do_emit;
    logic do_flush;
    logic push;

    assign out_free = ~r_ov | i_m_tready;
    // Notices past the per-item limit are dropped silently.
    assign capped   = (r_cnt >= CNT_W'(MAX_NOTES));

    assign o_st.emit_ok  = capped | ~r_pv | out_free;
    assign o_st.flush_ok = ~r_pv | out_free;

    assign do_emit  = i_req.emit & o_st.emit_ok & ~capped;
    assign do_flush = i_req.flush & o_st.flush_ok;
    assign push     = r_pv & (do_emit | do_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (do_emit) begin
                r_pv <= 1'b1;
            end else if (do_flush) begin
                r_pv <= 1'b0;
            end

            if (do_flush) begin
                r_cnt <= '0;
            end else if (do_emit) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end

            if (push) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_pslot <= i_req.slot;
            r_pcode <= i_req.code;
        end
        if (push) begin
            r_oslot <= r_pslot;
            r_ocode <= r_pcode;
            r_olast <= do_flush;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OUT_TDATA_W'(r_oslot);
    assign o_m_tuser  = r_ocode;
    assign o_m_tlast  = r_olast;

endmodule

// ===== design/keyed_lock_table.sv =====
// Keyed lock table top level: command sequencer, slot mode flags, key and
// deadline RAMs. Depends on kl_pkg, kl_ram, kl_match and kl_notes.
//
//  Channel   Direction  Beat contents
//  --------  ---------  --------------------------------------------------------
//  s (in)    slave      tuser[2:0] cmd; tdata[4:0] slot, [68:5] key_low,
//                       [132:69] key_high, [140:133] data_byte
//  m (out)   master     tdata[4:0] target_slot; tuser[2:0] notice; tlast last
//  cfg       write      i_cfg_wen / i_cfg_wdata[15:0] hold_timeout
//
// Connects, rejected commands and waiter closes emit their notice and flush; a
// key request walks the slots at most once through the shared compare unit; an
// owner release or hang-up walks all slots to wake waiters; a tick walks the
// slots and runs a wake walk for every owner that expires. Reset idles all
// slots, zeroes time and sets hold_timeout to 30; the RAMs are not cleared.
// A stalled master side freezes the walk at the slot that wants to report.

module keyed_lock_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [kl_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // slot, key_low, key_high, data_byte
    input  logic [kl_pkg::CMD_W-1:0]       i_s_tuser,   // cmd
    // Master side.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [kl_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // target_slot
    output logic [kl_pkg::NOTICE_W-1:0]    o_m_tuser,   // notice
    output logic                           o_m_tlast,
    // Configuration.
    input  logic                           i_cfg_wen,
    input  logic [kl_pkg::HOLD_W-1:0]      i_cfg_wdata
);
    import kl_pkg::*;

    // Unpacked input fields.
    logic [SLOT_FW-1:0] in_slot;
    logic [63:0]        in_key_low;
    logic [63:0]        in_key_high;
    logic [BYTE_W-1:0]  in_byte;
    logic [SLOT_W-1:0]  in_idx;
    logic               in_bad;
    logic               acc;

    assign in_slot     = i_s_tdata[4:0];
    assign in_key_low  = i_s_tdata[68:5];
    assign in_key_high = i_s_tdata[132:69];
    assign in_byte     = i_s_tdata[140:133];
    assign in_idx      = SLOT_W'(in_slot);
    // Unknown commands and out-of-range slots are rejected; ticks have no slot.
    assign in_bad      = (i_s_tuser > CMD_TICK) || (32'(in_slot) >= SLOTS);

    // Sequencer state and working registers.
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [SLOT_W-1:0]   r_own, n_own;
    logic [SLOT_FW-1:0]  r_nslot, n_nslot;
    t_notice             r_code, n_code;
    logic                r_tick, n_tick;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [HOLD_W-1:0]   r_hold;
    t_mode               r_mode [SLOTS];

    // Mode flag access: one read address, one write port.
    logic [SLOT_W-1:0]   mode_ra;
    t_mode               cur_mode;
    logic                m_we;
    logic [SLOT_W-1:0]   m_wa;
    t_mode               m_wd;

    // RAM ports and compare results.
    logic                key_we;
    logic                dl_we;
    logic [KEY_W-1:0]    key_dout;
    logic [TIME_W-1:0]   dl_dout;
    logic                key_eq;
    logic                expired;

    // Notice stage link.
    t_note_req           req;
    t_note_st            st;

    logic last_idx;
    logic own_last;
    logic wake_hit;
    logic req_hit;
    logic tick_hit;

    assign acc        = i_s_tvalid & o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    assign mode_ra  = (r_state == S_IDLE) ? in_idx : r_idx;
    assign cur_mode = r_mode[mode_ra];

    assign last_idx = (r_idx == SLOT_W'(SLOTS - 1));
    assign own_last = (r_own == SLOT_W'(SLOTS - 1));
    assign wake_hit = (cur_mode == MODE_WAITER) && key_eq;
    assign req_hit  = (cur_mode == MODE_OWNER) && key_eq;
    assign tick_hit = (cur_mode == MODE_OWNER) && expired;

    // The RAMs read at the next walk index, so their data lines up with r_idx.
    kl_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (in_idx),
        .i_wdata ({in_key_high, in_key_low}),
        .i_raddr (n_idx),
        .o_rdata (key_dout)
    );

    kl_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (r_own),
        .i_wdata (r_time + TIME_W'(r_hold)),
        .i_raddr (n_idx),
        .o_rdata (dl_dout)
    );

    kl_match u_match (
        .i_key_a    (key_dout),
        .i_key_b    (r_key),
        .i_now      (r_time),
        .i_deadline (dl_dout),
        .o_eq       (key_eq),
        .o_expired  (expired)
    );

    kl_notes u_notes (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_st       (st),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_s_tuser == CMD_TICK) begin
                        n_state = S_TICK;
                    end else if (in_bad) begin
                        n_state = S_LAST;
                    end else if (i_s_tuser == CMD_KEY && cur_mode == MODE_KEYWAIT) begin
                        n_state = S_REQ;
                    end else if ((i_s_tuser == CMD_DATA || i_s_tuser == CMD_HANGUP)
                                 && cur_mode == MODE_OWNER) begin
                        n_state = S_GRAB;
                    end else begin
                        n_state = S_LAST;
                    end
                end
            end
            S_GRAB: begin
                n_state = S_WAKE;
            end
            S_WAKE: begin
                if ((!wake_hit || st.emit_ok) && last_idx) begin
                    n_state = S_LAST;
                end
            end
            S_TICK: begin
                if (tick_hit) begin
                    n_state = S_WAKE;
                end else if (last_idx) begin
                    n_state = S_FLUSH;
                end
            end
            S_REQ: begin
                if (req_hit || last_idx) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (st.emit_ok) begin
                    n_state = (r_tick && !own_last) ? S_TICK : S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (st.flush_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control and register next values.
    always_comb begin
        n_idx   = r_idx;
        n_own   = r_own;
        n_nslot = r_nslot;
        n_code  = r_code;
        n_tick  = r_tick;
        n_key   = r_key;
        n_time  = r_time;
        m_we    = 1'b0;
        m_wa    = r_idx;
        m_wd    = MODE_IDLE;
        key_we  = 1'b0;
        dl_we   = 1'b0;
        req     = '{emit: 1'b0, flush: 1'b0, slot: r_nslot, code: r_code};

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_tick  = (i_s_tuser == CMD_TICK);
                    n_nslot = in_slot;
                    n_own   = in_idx;
                    n_idx   = '0;
                    n_code  = N_IGNORED;
                    m_wa    = in_idx;
                    if (i_s_tuser == CMD_TICK) begin
                        n_time = r_time + 1'b1;
                    end else if (!in_bad) begin
                        case (i_s_tuser)
                            CMD_CONNECT: begin
                                if (cur_mode == MODE_IDLE) begin
                                    m_we   = 1'b1;
                                    m_wd   = MODE_KEYWAIT;
                                    n_code = N_REOPEN;
                                end
                            end
                            CMD_KEY: begin
                                if (cur_mode == MODE_KEYWAIT) begin
                                    key_we = 1'b1;
                                    n_key  = {in_key_high, in_key_low};
                                end
                            end
                            CMD_DATA: begin
                                // An owner gives up its mode now; the walk
                                // that follows only looks at waiters.
                                if (cur_mode == MODE_OWNER) begin
                                    n_idx = in_idx;
                                    m_we  = 1'b1;
                                    if (in_byte == RELEASE_BYTE) begin
                                        m_wd   = MODE_KEYWAIT;
                                        n_code = N_REOPEN;
                                    end else begin
                                        m_wd   = MODE_IDLE;
                                        n_code = N_CLOSED;
                                    end
                                end else if (cur_mode == MODE_WAITER) begin
                                    m_we   = 1'b1;
                                    m_wd   = MODE_IDLE;
                                    n_code = N_CLOSED;
                                end
                            end
                            CMD_HANGUP: begin
                                if (cur_mode == MODE_OWNER) begin
                                    n_idx  = in_idx;
                                    m_we   = 1'b1;
                                    m_wd   = MODE_IDLE;
                                    n_code = N_CLOSED;
                                end else if (cur_mode != MODE_IDLE) begin
                                    m_we   = 1'b1;
                                    m_wd   = MODE_IDLE;
                                    n_code = N_CLOSED;
                                end
                            end
                            default: begin
                                n_code = N_IGNORED;
                            end
                        endcase
                    end
                end
            end
            S_GRAB: begin
                n_key = key_dout;
                n_idx = '0;
            end
            S_WAKE: begin
                if (wake_hit) begin
                    req.emit = 1'b1;
                    req.slot = SLOT_FW'(r_idx);
                    req.code = N_WOKEN;
                    if (st.emit_ok) begin
                        m_we = 1'b1;
                        m_wd = MODE_KEYWAIT;
                    end
                end
                if ((!wake_hit || st.emit_ok) && !last_idx) begin
                    n_idx = SLOT_W'(r_idx + 1'b1);
                end
            end
            S_TICK: begin
                if (tick_hit) begin
                    m_we    = 1'b1;
                    m_wd    = MODE_IDLE;
                    n_own   = r_idx;
                    n_nslot = SLOT_FW'(r_idx);
                    n_code  = N_CLOSED;
                    n_key   = key_dout;
                    n_idx   = '0;
                end else if (!last_idx) begin
                    n_idx = SLOT_W'(r_idx + 1'b1);
                end
            end
            S_REQ: begin
                if (req_hit || last_idx) begin
                    m_we = 1'b1;
                    m_wa = r_own;
                    if (req_hit) begin
                        m_wd   = MODE_WAITER;
                        n_code = N_WAITING;
                    end else begin
                        m_wd   = MODE_OWNER;
                        n_code = N_GRANTED;
                        dl_we  = 1'b1;
                    end
                end else begin
                    n_idx = SLOT_W'(r_idx + 1'b1);
                end
            end
            S_LAST: begin
                req.emit = 1'b1;
                // After an expired owner's close, the tick walk resumes
                // at the next slot.
                if (st.emit_ok && r_tick && !own_last) begin
                    n_idx = SLOT_W'(r_own + 1'b1);
                end
            end
            S_FLUSH: begin
                req.flush = 1'b1;
            end
            default: begin
                req.emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
            r_hold  <= HOLD_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i] <= MODE_IDLE;
            end
        end else begin
            r_state <= n_state;
            r_time  <= n_time;
            if (i_cfg_wen) begin
                r_hold <= i_cfg_wdata;
            end
            if (m_we) begin
                r_mode[m_wa] <= m_wd;
            end
        end
    end

    // Working registers; every path sets them before use.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_own   <= n_own;
        r_nslot <= n_nslot;
        r_code  <= n_code;
        r_tick  <= n_tick;
        r_key   <= n_key;
    end

endmodule
